// ===== hdl/tcci_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcci_pkg
// Shared types, constants and the pose microprogram for the three-circle
// intrusion block.
// ----------------------------------------------------------------------------
package tcci_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] REG_ROBOT_RADIUS    = 2'd0;
    localparam logic [1:0] REG_OBSTACLE_RADIUS = 2'd1;
    localparam logic [1:0] REG_CIRCLE_OFFSET   = 2'd2;

    localparam logic [19:0] RST_ROBOT_RADIUS    = 20'd73728;
    localparam logic [19:0] RST_OBSTACLE_RADIUS = 20'd32768;
    localparam logic [19:0] RST_CIRCLE_OFFSET   = 20'd83558;

    // sine polynomial coefficients, Q30
    localparam logic [31:0] SIN_C1 = 32'd1686629713;
    localparam logic [31:0] SIN_C3 = 32'd693598669;
    localparam logic [31:0] SIN_C5 = 32'd85569306;
    localparam logic [31:0] SIN_C7 = 32'd5026995;
    localparam logic [31:0] SIN_C9 = 32'd172272;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam int SQRT_STEPS = 22;
    localparam int POSE_STEPS = 31;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP, OP_X, OP_MUL_XX, OP_SET_X2, OP_MUL_X2S, OP_POLY, OP_MUL_XS,
        OP_SET_TRIG, OP_MUL_OFFX, OP_SET_OX, OP_MUL_OFFY, OP_SET_OY,
        OP_SET_CIRC, OP_DIFF, OP_MUL_DX, OP_SET_D2, OP_MUL_DY, OP_ADD_D2,
        OP_SQRT, OP_UPDATE, OP_FIN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
        logic       load_in;
    } t_cmd;

    typedef struct packed {
        logic is_pose;
        logic is_last;
        logic far;
        logic emit;
        logic out_full;
    } t_stat;

    // coefficient for a Horner step, highest order first
    function automatic logic [31:0] poly_coef(input logic [1:0] k);
        logic [31:0] c;
        unique case (k)
            2'd0: c = SIN_C7;
            2'd1: c = SIN_C5;
            2'd2: c = SIN_C3;
            default: c = SIN_C1;
        endcase
        return c;
    endfunction

    // pose program: two sine passes, then offsets and circle centres
    function automatic t_cmd pose_cmd(input logic [4:0] step);
        t_cmd       c;
        logic       p;
        logic [4:0] s;
        logic [4:0] t;
        c.op      = OP_NOP;
        c.idx     = 2'd0;
        c.load_in = 1'b0;
        p = (step >= 5'd13);
        s = p ? (step - 5'd13) : step;
        t = s - 5'd4;
        priority if (step == 5'd26) begin
            c.op = OP_MUL_OFFX;
        end else if (step == 5'd27) begin
            c.op = OP_SET_OX;
        end else if (step == 5'd28) begin
            c.op = OP_MUL_OFFY;
        end else if (step == 5'd29) begin
            c.op = OP_SET_OY;
        end else if (step == 5'd30) begin
            c.op = OP_SET_CIRC;
        end else if (step > 5'd30) begin
            c.op = OP_NOP;
        end else if (s == 5'd0) begin
            c.op  = OP_X;
            c.idx = {1'b0, p};
        end else if (s == 5'd1) begin
            c.op = OP_MUL_XX;
        end else if (s == 5'd2) begin
            c.op = OP_SET_X2;
        end else if (s == 5'd11) begin
            c.op = OP_MUL_XS;
        end else if (s == 5'd12) begin
            c.op  = OP_SET_TRIG;
            c.idx = {1'b0, p};
        end else if (s[0]) begin
            c.op = OP_MUL_X2S;
        end else begin
            c.op  = OP_POLY;
            c.idx = t[2:1];
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/tcci_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcci_ctrl
// Sequencer: runs the pose program or the per-circle obstacle steps and
// closes the frame.
// ----------------------------------------------------------------------------
module tcci_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire tcci_pkg::t_stat i_stat,
    output tcci_pkg::t_cmd       o_cmd
);
    import tcci_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_DISP = 10'b00_0000_0010,
        S_POSE = 10'b00_0000_0100,
        S_DIFF = 10'b00_0000_1000,
        S_CHK  = 10'b00_0001_0000,
        S_SQ   = 10'b00_0010_0000,
        S_SQRT = 10'b00_0100_0000,
        S_UPD  = 10'b00_1000_0000,
        S_END  = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [1:0] r_ci, n_ci;

    // next state and command
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_ci        = r_ci;
        o_cmd.op      = OP_NOP;
        o_cmd.idx     = r_ci;
        o_cmd.load_in = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_step = 5'd0;
                n_ci   = 2'd0;
                n_state = i_stat.is_pose ? S_POSE : S_DIFF;
            end
            S_POSE: begin
                o_cmd  = pose_cmd(r_step);
                n_step = r_step + 5'd1;
                if (r_step == 5'(POSE_STEPS - 1)) begin
                    n_state = S_END;
                end
            end
            S_DIFF: begin
                o_cmd.op = OP_DIFF;
                n_state  = S_CHK;
            end
            S_CHK: begin
                n_step = 5'd0;
                priority if (!i_stat.far) begin
                    n_state = S_SQ;
                end else if (r_ci == 2'd2) begin
                    n_state = S_END;
                end else begin
                    n_ci    = r_ci + 2'd1;
                    n_state = S_DIFF;
                end
            end
            S_SQ: begin
                unique case (r_step[1:0])
                    2'd0: o_cmd.op = OP_MUL_DX;
                    2'd1: o_cmd.op = OP_SET_D2;
                    2'd2: o_cmd.op = OP_MUL_DY;
                    default: o_cmd.op = OP_ADD_D2;
                endcase
                n_step = r_step + 5'd1;
                if (r_step[1:0] == 2'd3) begin
                    n_step  = 5'd0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_step   = r_step + 5'd1;
                if (r_step == 5'(SQRT_STEPS - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.op = OP_UPDATE;
                if (r_ci == 2'd2) begin
                    n_state = S_END;
                end else begin
                    n_ci    = r_ci + 2'd1;
                    n_state = S_DIFF;
                end
            end
            S_END: begin
                n_state = i_stat.is_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                // hold while a changed result cannot enter a full output stage
                if (!(i_stat.emit && i_stat.out_full)) begin
                    o_cmd.op = OP_FIN;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 5'd0;
            r_ci    <= 2'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ci    <= n_ci;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/tcci_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tcci_dp
// Datapath: configuration, shared multiplier, sine polynomial, circle
// centres, distance square root, running maximum and output stage.
// ----------------------------------------------------------------------------
module tcci_dp (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_command,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic [15:0]        i_heading,
    input  wire logic               i_last,
    input  wire tcci_pkg::t_cmd     i_cmd,
    output tcci_pkg::t_stat         o_stat,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [20:0]             o_max_intrusion,
    output logic                    o_collision_started
);
    import tcci_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        priority if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [19:0] r_rrad, r_orad, r_off;
    logic               r_pose, r_last;
    logic signed [31:0] r_px, r_py;
    logic [15:0]        r_head;
    logic [30:0]        r_xv, r_x2, r_sa, r_sb;
    logic [31:0]        r_s;
    logic [63:0]        r_prod;
    logic signed [21:0] r_ox, r_oy;
    logic signed [31:0] r_cx [3];
    logic signed [31:0] r_cy [3];
    logic [20:0]        r_adx, r_ady;
    logic               r_far;
    logic [43:0]        r_d2;
    logic [24:0]        r_rem;
    logic [21:0]        r_root;
    logic [20:0]        r_max, r_prev;
    logic               r_have;
    logic               r_out_valid;
    logic [20:0]        r_out_max;
    logic               r_out_cs;

    logic [20:0] rsum;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [14:0] frac;
    logic [30:0] xv;
    logic [1:0]  quad;
    logic [30:0] trig_x, trig_y;
    logic        neg_x, neg_y;
    logic [63:0] rounded;
    logic [21:0] mag;
    logic [33:0] trig_full;
    logic [31:0] poly_next;
    logic signed [31:0] sel_cx, sel_cy;
    logic signed [32:0] dx, dy;
    logic [32:0] adx, ady;
    logic [24:0] rem_next, trial;
    logic [21:0] intr;
    logic        emit;

    assign rsum = {1'b0, r_rrad} + {1'b0, r_orad};
    assign quad = r_head[15:14];
    assign frac = i_cmd.idx[0] ? (15'd16384 - {1'b0, r_head[13:0]}) : {1'b0, r_head[13:0]};
    assign xv   = {frac, 16'd0};

    // trig selection by quadrant
    assign trig_x = quad[0] ? r_sa : r_sb;
    assign trig_y = quad[0] ? r_sb : r_sa;
    assign neg_x  = quad[1] ^ quad[0];
    assign neg_y  = quad[1];

    // shared multiplier operand select
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (i_cmd.op)
            OP_MUL_XX:   begin mul_a = {1'b0, r_xv};   mul_b = {1'b0, r_xv}; end
            OP_MUL_X2S:  begin mul_a = {1'b0, r_x2};   mul_b = r_s; end
            OP_MUL_XS:   begin mul_a = {1'b0, r_xv};   mul_b = r_s; end
            OP_MUL_OFFX: begin mul_a = {12'd0, r_off}; mul_b = {1'b0, trig_x}; end
            OP_MUL_OFFY: begin mul_a = {12'd0, r_off}; mul_b = {1'b0, trig_y}; end
            OP_MUL_DX:   begin mul_a = {11'd0, r_adx}; mul_b = {11'd0, r_adx}; end
            OP_MUL_DY:   begin mul_a = {11'd0, r_ady}; mul_b = {11'd0, r_ady}; end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;

    // post-product arithmetic
    assign rounded   = r_prod + 64'h2000_0000;
    assign mag       = {1'b0, rounded[50:30]};
    assign trig_full = r_prod[63:30];
    assign poly_next = poly_coef(i_cmd.idx) - r_prod[61:30];

    // obstacle differences
    always_comb begin
        unique case (i_cmd.idx)
            2'd0: begin sel_cx = r_cx[0]; sel_cy = r_cy[0]; end
            2'd1: begin sel_cx = r_cx[1]; sel_cy = r_cy[1]; end
            default: begin sel_cx = r_cx[2]; sel_cy = r_cy[2]; end
        endcase
        dx  = {sel_cx[31], sel_cx} - {r_px[31], r_px};
        dy  = {sel_cy[31], sel_cy} - {r_py[31], r_py};
        adx = dx[32] ? 33'(-dx) : 33'(dx);
        ady = dy[32] ? 33'(-dy) : 33'(dy);
    end

    // one root bit per step
    assign rem_next = {r_rem[22:0], r_d2[43:42]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign intr     = {1'b0, rsum} - r_root;
    assign emit     = !r_have || (r_max != r_prev);

    assign o_stat.is_pose  = r_pose;
    assign o_stat.is_last  = r_last;
    assign o_stat.far      = r_far;
    assign o_stat.emit     = emit;
    assign o_stat.out_full = r_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rrad <= RST_ROBOT_RADIUS;
            r_orad <= RST_OBSTACLE_RADIUS;
            r_off  <= RST_CIRCLE_OFFSET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROBOT_RADIUS:    r_rrad <= i_cfg_data[19:0];
                REG_OBSTACLE_RADIUS: r_orad <= i_cfg_data[19:0];
                REG_CIRCLE_OFFSET:   r_off  <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // input capture and working registers
    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        if (i_cmd.load_in) begin
            r_pose <= !i_command;
            r_last <= i_last;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_head <= i_heading;
        end
        unique case (i_cmd.op)
            OP_X: begin
                r_xv <= xv;
                r_s  <= SIN_C9;
            end
            OP_SET_X2: r_x2 <= r_prod[60:30];
            OP_POLY:   r_s  <= poly_next;
            OP_SET_TRIG: begin
                if (i_cmd.idx[0]) begin
                    r_sb <= (trig_full > 34'(Q30_ONE)) ? Q30_ONE : trig_full[30:0];
                end else begin
                    r_sa <= (trig_full > 34'(Q30_ONE)) ? Q30_ONE : trig_full[30:0];
                end
            end
            OP_SET_OX: r_ox <= neg_x ? -$signed(mag) : $signed(mag);
            OP_SET_OY: r_oy <= neg_y ? -$signed(mag) : $signed(mag);
            OP_DIFF: begin
                r_adx <= adx[20:0];
                r_ady <= ady[20:0];
                r_far <= (adx >= {12'd0, rsum}) || (ady >= {12'd0, rsum});
            end
            OP_SET_D2: r_d2 <= r_prod[43:0];
            OP_ADD_D2: begin
                r_d2   <= r_d2 + r_prod[43:0];
                r_rem  <= 25'd0;
                r_root <= 22'd0;
            end
            OP_SQRT: begin
                r_d2 <= {r_d2[41:0], 2'b00};
                if (rem_next >= trial) begin
                    r_rem  <= rem_next - trial;
                    r_root <= {r_root[20:0], 1'b1};
                end else begin
                    r_rem  <= rem_next;
                    r_root <= {r_root[20:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // circle centres, running maximum, report state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cx[k] <= 32'sd0;
                r_cy[k] <= 32'sd0;
            end
            r_max       <= 21'd0;
            r_prev      <= 21'd0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_SET_CIRC: begin
                    r_cx[0] <= sat32(34'(r_px) - 34'(r_ox));
                    r_cy[0] <= sat32(34'(r_py) - 34'(r_oy));
                    r_cx[1] <= r_px;
                    r_cy[1] <= r_py;
                    r_cx[2] <= sat32(34'(r_px) + 34'(r_ox));
                    r_cy[2] <= sat32(34'(r_py) + 34'(r_oy));
                    r_max   <= 21'd0;
                end
                OP_UPDATE: begin
                    if (!r_far && (r_root < {1'b0, rsum}) && (intr[20:0] > r_max)) begin
                        r_max <= intr[20:0];
                    end
                end
                OP_FIN: begin
                    if (emit) begin
                        r_out_valid <= 1'b1;
                        r_out_max   <= r_max;
                        r_out_cs    <= (r_max != 21'd0) && r_have && (r_prev == 21'd0);
                        r_prev      <= r_max;
                        r_have      <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_max_intrusion     = r_out_max;
    assign o_collision_started = r_out_cs;

endmodule
`default_nettype wire

// ===== hdl/three_circle_collision_intrusion.sv =====
`default_nettype none
// Pose item: 31 steps on one shared multiplier between transfer and ready again.
// Obstacle item: each of three circles runs the 22-step bit-serial square root, and
// a far circle ends after the difference and check steps, without the square root.
// One item at a time; a finished result waits in the output register while the next
// item is taken. Synchronous active-low reset restores register defaults and clears state.
// ----------------------------------------------------------------------------
// three_circle_collision_intrusion
// Deepest overlap of a three-circle robot against circular obstacles, reported
// per frame when it changes.
// ----------------------------------------------------------------------------
module three_circle_collision_intrusion (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_command,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic [15:0]        i_heading,
    input  wire logic               i_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [20:0]             o_max_intrusion,
    output logic                    o_collision_started
);
    import tcci_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    // sequencer
    tcci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    tcci_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_command           (i_command),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_heading           (i_heading),
        .i_last              (i_last),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_max_intrusion     (o_max_intrusion),
        .o_collision_started (o_collision_started)
    );

endmodule
`default_nettype wire
